// ----- sv/otsb_pkg.sv -----
// Shared types, constants and helper functions for the overlapping time slice builder.
// Used by otsb_ctrl, otsb_dpath and overlapping_time_slice_builder.
package otsb_pkg;

    // Fixed sizes
    localparam int unsigned HDR_WORDS      = 8;    // header words added to each closed slice
    localparam int unsigned MAX_CLOSES_DEF = 62;   // closes per event before gap overflow
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned CFG_DATA_W     = 32;
    localparam int unsigned IN_DATA_W      = 128;
    localparam int unsigned OUT_DATA_W     = 248;

    // Configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_SLICE_LENGTH  = 3'd0;
    localparam t_cfg_idx CFG_SLICE_OVERLAP = 3'd1;
    localparam t_cfg_idx CFG_USE_EXT_TIME  = 3'd2;
    localparam t_cfg_idx CFG_IDLE_LIMIT    = 3'd3;
    localparam t_cfg_idx CFG_IDLE_CREDIT   = 3'd4;

    // Register reset values
    localparam logic [31:0] LEN_RST    = 32'd100000000;
    localparam logic [31:0] OVL_RST    = 32'd10000000;
    localparam logic [15:0] LIMIT_RST  = 16'd1000;
    localparam logic [15:0] CREDIT_RST = 16'd781;
    localparam logic [32:0] WIN_RST    = 33'(LEN_RST) + 33'(OVL_RST);
    localparam logic [33:0] LW_RST     = 34'(WIN_RST) + 34'(LEN_RST);

    // Result kinds
    typedef enum logic [1:0] {
        KIND_PLACED   = 2'd0,
        KIND_CLOSED   = 2'd1,
        KIND_BAD      = 2'd2,
        KIND_OVERFLOW = 2'd3
    } t_kind;

    // Controller to datapath commands
    typedef struct packed {
        logic  take;       // input transfer accepted
        logic  calc_diff;  // offset of event from slice start
        logic  add_cur;    // count event in current slice
        logic  add_nxt;    // count event in next slice too
        logic  close;      // close current slice, advance one slice
        logic  idle_sub;   // take idle credit off after a forced close
        logic  restart;    // restart slicing at the event time
        logic  emit;       // load output register
        t_kind kind;
        logic  last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;    // output register can take a result
        logic t_before;    // event earlier than slice start
        logic d_lt_len;    // offset below slice length
        logic d_lt_win;    // offset below length plus overlap
        logic d_gt_len;    // offset above slice length
        logic d_gt_lw;     // offset still beyond window after one more close
        logic n_at_max;    // this close is the last one allowed
        logic idle_over;   // idle count past limit after a first event
    } t_stat;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = 33'(a) + 33'(b);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] a);
        return (a == 16'hFFFF) ? a : a + 16'd1;
    endfunction

endpackage

// ----- sv/otsb_ctrl.sv -----
// Sequencing state machine for the overlapping time slice builder.
// Depends on otsb_pkg; drives otsb_dpath through t_cmd and reads t_stat.
module otsb_ctrl import otsb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  logic  i_poll,
    output logic  o_s_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b0_0000_0001,
        S_POLL  = 9'b0_0000_0010,
        S_DIFF  = 9'b0_0000_0100,
        S_CLASS = 9'b0_0000_1000,
        S_BAD   = 9'b0_0001_0000,
        S_CLOSE = 9'b0_0010_0000,
        S_OVF   = 9'b0_0100_0000,
        S_POST  = 9'b0_1000_0000,
        S_PLACE = 9'b1_0000_0000
    } t_state;

    t_state r_state, n_state;

    assign o_s_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.kind = KIND_PLACED;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.take = 1'b1;
                    n_state = i_poll ? S_POLL : S_DIFF;
                end
            end
            S_POLL: begin
                if (!i_stat.idle_over) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.close    = 1'b1;
                    o_cmd.idle_sub = 1'b1;
                    o_cmd.emit     = 1'b1;
                    o_cmd.kind     = KIND_CLOSED;
                    o_cmd.last     = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_DIFF: begin
                o_cmd.calc_diff = 1'b1;
                n_state = S_CLASS;
            end
            S_CLASS: begin
                if (i_stat.t_before) begin
                    n_state = S_BAD;
                end else if (i_stat.d_lt_len) begin
                    o_cmd.add_cur = 1'b1;
                    n_state = S_PLACE;
                end else if (i_stat.d_lt_win) begin
                    o_cmd.add_cur = 1'b1;
                    o_cmd.add_nxt = 1'b1;
                    n_state = S_PLACE;
                end else begin
                    n_state = S_CLOSE;
                end
            end
            S_BAD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_BAD;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CLOSE: begin
                if (i_stat.out_free) begin
                    o_cmd.close = 1'b1;
                    o_cmd.emit  = 1'b1;
                    o_cmd.kind  = KIND_CLOSED;
                    if (i_stat.d_gt_lw && !i_stat.n_at_max) begin
                        n_state = S_CLOSE;
                    end else if (i_stat.d_gt_lw) begin
                        n_state = S_OVF;
                    end else begin
                        n_state = S_POST;
                    end
                end
            end
            S_OVF: begin
                if (i_stat.out_free) begin
                    o_cmd.emit    = 1'b1;
                    o_cmd.kind    = KIND_OVERFLOW;
                    o_cmd.restart = 1'b1;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                o_cmd.add_cur = 1'b1;
                o_cmd.add_nxt = i_stat.d_gt_len;
                n_state = S_PLACE;
            end
            S_PLACE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.kind = KIND_PLACED;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/otsb_dpath.sv -----
// Datapath for the overlapping time slice builder: config registers, slice state,
// offset arithmetic and the output register. Depends on otsb_pkg.
module otsb_dpath import otsb_pkg::*; #(
    parameter int unsigned MAX_CLOSES = MAX_CLOSES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_s_data,
    input  logic                  i_poll,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic                  i_m_ready,
    output logic                  o_m_valid,
    output logic [OUT_DATA_W-1:0] o_m_data,
    output logic [1:0]            o_m_kind,
    output logic                  o_m_last
);

    localparam int unsigned N_W = (MAX_CLOSES > 1) ? $clog2(MAX_CLOSES) : 1;

    // Configuration
    logic [31:0] r_len, r_ovl;
    logic [32:0] r_win;      // length + overlap
    logic [33:0] r_lw;       // 2 * length + overlap
    logic        r_ext;
    logic [15:0] r_limit, r_credit;

    // Slice state
    logic [63:0] r_start, r_t, r_d;
    logic        r_before, r_seen, r_also;
    logic [16:0] r_idle;
    logic [15:0] r_w, r_cur_trig, r_nxt_trig;
    logic [31:0] r_cur_words, r_nxt_words;
    logic [N_W-1:0] r_n;

    // Output register
    logic                  r_m_valid, r_m_last;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic [1:0]            r_m_kind;

    logic [63:0] t_in, finish;
    logic [64:0] diff;
    logic [OUT_DATA_W-1:0] n_m_data;

    // Timestamp assembly from the input words
    always_comb begin
        if (r_ext) begin
            t_in = i_s_data[63:0];
        end else begin
            t_in = {16'h0000, i_s_data[111:64]};
        end
    end

    assign diff   = {1'b0, r_t} - {1'b0, r_start};
    assign finish = r_start + 64'(r_win);

    // Config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_RST;
            r_ovl    <= OVL_RST;
            r_win    <= WIN_RST;
            r_lw     <= LW_RST;
            r_ext    <= 1'b0;
            r_limit  <= LIMIT_RST;
            r_credit <= CREDIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SLICE_LENGTH: begin
                    r_len <= i_cfg_data;
                    r_win <= 33'(i_cfg_data) + 33'(r_ovl);
                    r_lw  <= 34'({i_cfg_data, 1'b0}) + 34'(r_ovl);
                end
                CFG_SLICE_OVERLAP: begin
                    r_ovl <= i_cfg_data;
                    r_win <= 33'(r_len) + 33'(i_cfg_data);
                    r_lw  <= 34'({r_len, 1'b0}) + 34'(i_cfg_data);
                end
                CFG_USE_EXT_TIME: r_ext    <= i_cfg_data[0];
                CFG_IDLE_LIMIT:   r_limit  <= i_cfg_data[15:0];
                CFG_IDLE_CREDIT:  r_credit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Slice state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_seen      <= 1'b0;
            r_idle      <= '0;
            r_cur_trig  <= '0;
            r_cur_words <= '0;
            r_nxt_trig  <= '0;
            r_nxt_words <= '0;
            r_n         <= '0;
            r_also      <= 1'b0;
        end else begin
            // accepted transfer
            if (i_cmd.take) begin
                r_t <= t_in;
                r_w <= i_s_data[127:112];
                if (i_poll) begin
                    if (r_idle != '1) begin
                        r_idle <= r_idle + 17'd1;
                    end
                end else begin
                    r_idle <= '0;
                    if (!r_seen) begin
                        r_start <= t_in;
                        r_seen  <= 1'b1;
                    end
                end
            end
            // offset from slice start, borrow flags an early event
            if (i_cmd.calc_diff) begin
                r_before <= diff[64];
                r_d      <= diff[63:0];
                r_n      <= '0;
            end
            // close and advance one slice
            if (i_cmd.close) begin
                r_start     <= r_start + 64'(r_len);
                r_d         <= r_d - 64'(r_len);
                r_cur_trig  <= r_nxt_trig;
                r_cur_words <= r_nxt_words;
                r_nxt_trig  <= '0;
                r_nxt_words <= '0;
                r_n         <= r_n + N_W'(1);
            end
            if (i_cmd.idle_sub) begin
                r_idle <= (r_idle > 17'(r_credit)) ? r_idle - 17'(r_credit) : '0;
            end
            // gap overflow: slicing restarts at the event
            if (i_cmd.restart) begin
                r_start     <= r_t;
                r_d         <= '0;
                r_cur_trig  <= '0;
                r_cur_words <= '0;
                r_nxt_trig  <= '0;
                r_nxt_words <= '0;
            end
            // counting
            if (i_cmd.add_cur) begin
                r_cur_trig  <= sat_inc16(r_cur_trig);
                r_cur_words <= sat_add32(r_cur_words, 32'(r_w));
                r_also      <= i_cmd.add_nxt;
                if (i_cmd.add_nxt) begin
                    r_nxt_trig  <= sat_inc16(r_nxt_trig);
                    r_nxt_words <= sat_add32(r_nxt_words, 32'(r_w));
                end
            end
        end
    end

    // Result payload by kind; fields a kind does not fill stay zero
    always_comb begin
        n_m_data = '0;
        case (i_cmd.kind)
            KIND_PLACED: begin
                n_m_data[0]       = r_also;
                n_m_data[64:1]    = r_t;
                n_m_data[128:65]  = r_start;
                n_m_data[192:129] = finish;
            end
            KIND_CLOSED: begin
                n_m_data[128:65]  = r_start;
                n_m_data[192:129] = finish;
                n_m_data[208:193] = r_cur_trig;
                n_m_data[240:209] = sat_add32(r_cur_words, 32'(HDR_WORDS));
            end
            KIND_BAD: begin
                n_m_data[64:1]    = r_t;
                n_m_data[128:65]  = r_start;
                n_m_data[192:129] = finish;
            end
            KIND_OVERFLOW: begin
                n_m_data[64:1]    = r_t;
            end
            default: n_m_data = '0;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_m_data <= n_m_data;
            r_m_kind <= i_cmd.kind;
            r_m_last <= i_cmd.last;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.out_free  = !r_m_valid || i_m_ready;
        o_stat.t_before  = r_before;
        o_stat.d_lt_len  = r_d < 64'(r_len);
        o_stat.d_lt_win  = r_d < 64'(r_win);
        o_stat.d_gt_len  = r_d > 64'(r_len);
        o_stat.d_gt_lw   = r_d > 64'(r_lw);
        o_stat.n_at_max  = (r_n == N_W'(MAX_CLOSES - 1));
        o_stat.idle_over = r_seen && (r_idle > 17'(r_limit));
    end

    assign o_m_valid = r_m_valid;
    assign o_m_data  = r_m_data;
    assign o_m_kind  = r_m_kind;
    assign o_m_last  = r_m_last;

endmodule

// ----- sv/overlapping_time_slice_builder.sv -----
// Overlapping time slice builder, top level: otsb_ctrl sequences, otsb_dpath computes.
// An event that closes k slices does one close per cycle through the slice adder while
// the output register is free; a gap overflow adds one more result.
// One item in work at a time: the next is accepted the cycle after the last result
// is loaded, and output stalls hold the sequencer.
// Reset (i_rst_n, synchronous, active low) restores register defaults and clears the sequencer, slice start and counts.
module overlapping_time_slice_builder import otsb_pkg::*; #(
    parameter int unsigned MAX_CLOSES = MAX_CLOSES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration writes
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // ext_time_w0, ext_time_w1, ext_time_w2, ext_time_w3,
    // int_time_w1, int_time_w2, int_time_w3, event_words
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,   // command
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // also_next, event_time, slice_begin, slice_finish, trigger_count, word_count, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]            m_axis_tuser,   // kind
    output logic                  m_axis_tlast    // last
);

    t_cmd  cmd;
    t_stat stat;

    otsb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_poll    (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    otsb_dpath #(
        .MAX_CLOSES (MAX_CLOSES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_data    (s_axis_tdata),
        .i_poll      (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_m_ready   (m_axis_tready),
        .o_m_valid   (m_axis_tvalid),
        .o_m_data    (m_axis_tdata),
        .o_m_kind    (m_axis_tuser),
        .o_m_last    (m_axis_tlast)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for overlapping_time_slice_builder: directed and random event/poll streams,
// checked field by field by a scoreboard class that tracks the slices itself.
// Depends on otsb_pkg and the builder RTL; needs no files or arguments.
module tb_top;
    import otsb_pkg::*;

    // Input command codes (tuser of the input stream)
    localparam logic CMD_EVENT = 1'b0;
    localparam logic CMD_POLL  = 1'b1;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 80;    // longest event: 62 closes plus an overflow
    localparam int PHASE_ITEMS    = 68;

    typedef struct packed {
        t_kind       kind;
        logic        also_next;
        logic [63:0] event_time;
        logic [63:0] slice_begin;
        logic [63:0] slice_finish;
        logic [15:0] trigger_count;
        logic [31:0] word_count;
        logic        last;
    } t_slice_report;

    // Tracks slice state and holds the reports the block owes us
    class t_slice_scoreboard;
        logic [31:0]   slice_len;
        logic [31:0]   slice_ovl;
        logic          use_ext;
        logic [15:0]   idle_limit;
        logic [15:0]   idle_credit;
        logic [63:0]   cur_start;
        logic          started;
        logic [16:0]   idle_cnt;
        logic [15:0]   cur_trig;
        logic [15:0]   nxt_trig;
        logic [31:0]   cur_words;
        logic [31:0]   nxt_words;
        t_slice_report pending_reports[$];
        int            errors;
        int            closes;
        int            forced;
        int            late;
        int            overflows;

        function new();
            slice_len   = LEN_RST;
            slice_ovl   = OVL_RST;
            use_ext     = 1'b0;
            idle_limit  = LIMIT_RST;
            idle_credit = CREDIT_RST;
            cur_start   = '0;
            started     = 1'b0;
            idle_cnt    = '0;
            cur_trig    = '0;
            nxt_trig    = '0;
            cur_words   = '0;
            nxt_words   = '0;
            errors      = 0;
            closes      = 0;
            forced      = 0;
            late        = 0;
            overflows   = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] val);
            case (idx)
                CFG_SLICE_LENGTH:  slice_len   = val;
                CFG_SLICE_OVERLAP: slice_ovl   = val;
                CFG_USE_EXT_TIME:  use_ext     = val[0];
                CFG_IDLE_LIMIT:    idle_limit  = val[15:0];
                CFG_IDLE_CREDIT:   idle_credit = val[15:0];
                default: ;
            endcase
        endfunction

        // Word counts stick at all ones
        function logic [31:0] add_words(logic [31:0] a, logic [31:0] b);
            return (a > ~b) ? 32'hFFFF_FFFF : a + b;
        endfunction

        function logic [63:0] finish_of();
            return cur_start + 64'(slice_len) + 64'(slice_ovl);
        endfunction

        function void report(t_kind kind, logic also, logic [63:0] t, logic [63:0] b,
                             logic [63:0] f, logic [15:0] trig, logic [31:0] words,
                             logic last);
            t_slice_report rep;
            rep = '{kind, also, t, b, f, trig, words, last};
            pending_reports.insert(pending_reports.size(), rep);
        endfunction

        // Report the current slice, step one slice length, carry next-slice counts
        function void close_slice(logic last);
            report(KIND_CLOSED, 1'b0, '0, cur_start, finish_of(), cur_trig,
                   add_words(cur_words, 32'(HDR_WORDS)), last);
            cur_start = cur_start + 64'(slice_len);
            cur_trig  = nxt_trig;
            cur_words = nxt_words;
            nxt_trig  = '0;
            nxt_words = '0;
            closes++;
        endfunction

        function void count_event(logic [31:0] w, logic both);
            if (cur_trig != 16'hFFFF)
                cur_trig = cur_trig + 16'd1;
            cur_words = add_words(cur_words, w);
            if (both) begin
                if (nxt_trig != 16'hFFFF)
                    nxt_trig = nxt_trig + 16'd1;
                nxt_words = add_words(nxt_words, w);
            end
        endfunction

        // Work out the reports one accepted input transfer causes
        function void predict_slices(logic cmd, logic [IN_DATA_W-1:0] d);
            logic [63:0] t;
            logic [63:0] span;
            logic [31:0] w;
            logic        also;
            int          n_close;

            // Idle poll: at most one forced close, otherwise silent
            if (cmd == CMD_POLL) begin
                if (idle_cnt != 17'h1FFFF)
                    idle_cnt = idle_cnt + 17'd1;
                if (started && idle_cnt > 17'(idle_limit)) begin
                    close_slice(1'b1);
                    idle_cnt = (idle_cnt > 17'(idle_credit)) ? idle_cnt - 17'(idle_credit) : '0;
                    forced++;
                end
                return;
            end

            idle_cnt = '0;
            t = use_ext ? d[63:0] : {16'h0, d[111:64]};
            w = {16'h0, d[127:112]};
            also = 1'b0;
            if (!started) begin
                cur_start = t;
                started = 1'b1;
            end

            // Late event: dropped
            if (t < cur_start) begin
                report(KIND_BAD, 1'b0, t, cur_start, finish_of(), '0, '0, 1'b1);
                late++;
                return;
            end

            span = 64'(slice_len) + 64'(slice_ovl);
            if (t - cur_start < 64'(slice_len)) begin
                count_event(w, 1'b0);
            end else if (t - cur_start < span) begin
                count_event(w, 1'b1);
                also = 1'b1;
            end else begin
                // Close the current slice and any empty ones in the gap
                close_slice(1'b0);
                n_close = 1;
                while (t - cur_start > span && n_close < MAX_CLOSES_DEF) begin
                    close_slice(1'b0);
                    n_close++;
                end
                // Gap too long: restart slicing at the event
                if (t - cur_start > span) begin
                    report(KIND_OVERFLOW, 1'b0, t, '0, '0, '0, '0, 1'b0);
                    cur_start = t;
                    cur_trig  = '0;
                    cur_words = '0;
                    nxt_trig  = '0;
                    nxt_words = '0;
                    overflows++;
                end
                also = (t - cur_start > 64'(slice_len));
                count_event(w, also);
            end
            report(KIND_PLACED, also, t, cur_start, finish_of(), '0, '0, 1'b1);
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
                errors++;
            end
        endfunction

        // Check one result transfer against the oldest owed report
        function void check_result(logic [OUT_DATA_W-1:0] d, logic [1:0] kind, logic last);
            t_slice_report want;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, kind %0d, event time %0h",
                         $time, kind, d[64:1]);
                errors++;
                return;
            end
            want = pending_reports.pop_front();
            compare("kind", 64'(want.kind), 64'(kind));
            compare("also_next", 64'(want.also_next), 64'(d[0]));
            compare("event_time", want.event_time, d[64:1]);
            compare("slice_begin", want.slice_begin, d[128:65]);
            compare("slice_finish", want.slice_finish, d[192:129]);
            compare("trigger_count", 64'(want.trigger_count), 64'(d[208:193]));
            compare("word_count", 64'(want.word_count), 64'(d[240:209]));
            compare("last", 64'(want.last), 64'(last));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    t_cfg_idx              i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;

    t_slice_scoreboard sb;
    int         burst_left   = 0;
    int         n_events     = 0;
    int         n_polls      = 0;
    int         quiet_cycles = 0;
    logic [7:0] stall_pat    = 8'hFF;
    int         stall_age    = 0;

    always #2 i_clk = ~i_clk;

    overlapping_time_slice_builder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Receiver stalls: rotating ready pattern, reloaded now and then, often all ready
    always @(posedge i_clk) begin
        if (stall_age == 0) begin
            stall_pat <= ($urandom_range(2) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
            stall_age <= $urandom_range(16, 96);
        end else begin
            stall_pat <= {stall_pat[0], stall_pat[7:1]};
            stall_age <= stall_age - 1;
        end
        m_axis_tready <= stall_pat[0];
    end

    // Result transfers go to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no transfer for %0d cycles", $time, quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // Event time aimed at the current slice: inside, overlap, short gaps, long gaps, late
    function automatic logic [63:0] pick_time();
        logic [63:0] span;
        logic [63:0] rnd;
        logic [63:0] base;
        int unsigned sel;
        span = 64'(sb.slice_len) + 64'(sb.slice_ovl);
        rnd  = {$urandom, $urandom};
        base = sb.cur_start;
        sel  = $urandom_range(99);
        if (sel < 6)
            return rnd;
        if (sel < 12)
            return base - 64'd1 - rnd % 64'd1000;
        if (sel < 45)
            return base + rnd % 64'(sb.slice_len);
        if (sel < 65)
            return base + 64'(sb.slice_len) + rnd % (64'(sb.slice_ovl) + 64'd1);
        if (sel < 92)
            return base + rnd % (span * 64'd4 + 64'd1);
        return base + span * 64'($urandom_range(40, 80)) + rnd % 64'(sb.slice_len);
    endfunction

    // Pack an event; the unused time source carries random bits
    function automatic logic [IN_DATA_W-1:0] build_event(logic [63:0] t, logic [15:0] w);
        logic [63:0] ext_t;
        logic [47:0] int_t;
        ext_t = {$urandom, $urandom};
        int_t = 48'({$urandom, $urandom});
        if (sb.use_ext)
            ext_t = t;
        else
            int_t = t[47:0];
        return {w, int_t, ext_t};
    endfunction

    // Sender bursts with random gaps between them
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic send_item(logic cmd, logic [IN_DATA_W-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.predict_slices(cmd, d);
        if (cmd == CMD_POLL)
            n_polls++;
        else
            n_events++;
        pace();
    endtask

    task automatic send_event(logic [63:0] t, logic [15:0] w);
        send_item(CMD_EVENT, build_event(t, w));
    endtask

    task automatic send_poll();
        send_item(CMD_POLL, {$urandom, $urandom, $urandom, $urandom});
    endtask

    task automatic wait_drained(int settle);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_reports.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    // Register write; leaves the write enable high for the caller to drop
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_config(logic [31:0] len, logic [31:0] ovl, logic ext,
                               logic [15:0] lim, logic [15:0] credit);
        write_reg(CFG_SLICE_LENGTH, len);
        write_reg(CFG_SLICE_OVERLAP, ovl);
        write_reg(CFG_USE_EXT_TIME, 32'(ext));
        write_reg(CFG_IDLE_LIMIT, 32'(lim));
        write_reg(CFG_IDLE_CREDIT, 32'(credit));
        i_cfg_we <= 1'b0;
    endtask

    // Random mix of events and polls, with one full drain halfway
    task automatic random_phase(int count);
        for (int k = 0; k < count; k++) begin
            if (k == count / 2)
                wait_drained(0);
            if ($urandom_range(3) == 0)
                send_poll();
            else
                send_event(pick_time(), 16'($urandom));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_SLICE_LENGTH;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= CMD_EVENT;
        s_axis_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Short slices, internal time, quick forced closes
        load_config(32'd10, 32'd3, 1'b0, 16'd2, 16'd1);
        send_poll();                      // poll before any event: silent
        send_event(64'd1000, 16'd0);      // first event sets the slice start
        send_event(64'd1009, 16'hFFFF);   // last tick of the slice, max words
        send_event(64'd1010, 16'd7);      // start of overlap
        send_event(64'd1012, 16'd3);      // end of overlap
        send_event(64'd999, 16'd1);       // late by one tick
        send_event(64'd1013, 16'd2);      // just past overlap: one close
        send_event(64'd1034, 16'd4);      // two closes
        send_event(64'd1052, 16'd6);      // close, then lands in overlap of new slice
        send_event(64'd5000, 16'd5);      // gap too long
        send_poll();
        send_poll();
        send_poll();                      // idle count passes limit: forced close
        send_poll();                      // credit leaves it at limit: closes again
        send_event(64'd0, 16'd9);         // earliest possible time, late
        send_event(64'hFFFF_FFFF_FFFF, 16'd1);  // max internal time, long gap
        send_event(64'hFFFF_FFFF_FFFF, 16'd1);
        random_phase(PHASE_ITEMS);
        wait_drained(SETTLE_CYCLES);

        // Register defaults
        load_config(LEN_RST, OVL_RST, 1'b0, LIMIT_RST, CREDIT_RST);
        random_phase(PHASE_ITEMS);
        wait_drained(SETTLE_CYCLES);

        // Credit larger than the count clamps it to zero
        load_config(32'd1000, 32'd500, 1'b0, 16'd3, 16'hFFFF);
        random_phase(PHASE_ITEMS);
        wait_drained(SETTLE_CYCLES);

        // Shortest slice, no overlap, external time, every poll closes
        load_config(32'd1, 32'd0, 1'b1, 16'd0, 16'd0);
        random_phase(PHASE_ITEMS);
        wait_drained(SETTLE_CYCLES);

        // Longest slice and overlap, then slice end wrapping past the top of time
        load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 16'hFFFF);
        random_phase(PHASE_ITEMS);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_event(64'd0, 16'd0);
        send_event(64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
        send_poll();
        wait_drained(SETTLE_CYCLES);

        $display("Run covered %0d events and %0d idle polls over five register settings,",
                 n_events, n_polls);
        $display("with %0d slice closes (%0d forced by idling), %0d late events, %0d %s",
                 sb.closes, sb.forced, sb.late, sb.overflows, "gap overflows.");
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
